// ===== rtl/ipmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ipmt_pkg
// Types and constants shared by the in-place matrix transpose block.
// ----------------------------------------------------------------------------
package ipmt_pkg;

	localparam int DIM_W  = 13;
	localparam int PROD_W = 2 * DIM_W;
	localparam int IDX_W  = 12;
	localparam int WORD_W = 64;

	localparam logic [1:0] REQ_WRITE     = 2'd0;
	localparam logic [1:0] REQ_TRANSPOSE = 2'd1;
	localparam logic [1:0] REQ_READ      = 2'd2;

	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_ERR = 1'b1;

	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]        op_echo;
		logic              status;
		logic [WORD_W-1:0] read_data;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESP,
		ST_SQ_RDA,
		ST_SQ_RDB,
		ST_SQ_WA,
		ST_SQ_WB,
		ST_CLR,
		ST_CHK,
		ST_CHK2,
		ST_LOAD,
		ST_DIV,
		ST_RD,
		ST_WR
	} state_t;

endpackage

// ===== rtl/ipmt_ram.sv =====
// ----------------------------------------------------------------------------
// ipmt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ipmt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ipmt_div.sv =====
// ----------------------------------------------------------------------------
// ipmt_div
// Restoring divider, one quotient bit per cycle; splits a flat index into
// row (quotient) and column (remainder).
// ----------------------------------------------------------------------------
module ipmt_div #(
	parameter int AW = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [AW-1:0]            dividend,
	input  logic [ipmt_pkg::DIM_W-1:0] divisor,
	output logic                     busy,
	output logic [AW-1:0]            quo,
	output logic [ipmt_pkg::DIM_W-1:0] rem
);

	import ipmt_pkg::*;

	localparam int CW = (AW > 1) ? $clog2(AW) : 1;

	logic              busy_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     quo_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[AW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(AW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[AW-2:0], fits};
			rem_q <= fits ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/in_place_matrix_transpose.sv =====
// Write and read: accept, then result register; no new request is taken until the block is back in idle.
// Transpose, square shape: each swapped pair is read at a, read at b, written at a, then at b, one RAM port pair.
// Transpose, other shape: all rows*cols visited-map entries are cleared, then
// each permutation cycle is followed, with the divider giving each moved word's destination.
// Reset clears control state; the matrix store is undefined until written.
// ----------------------------------------------------------------------------
// in_place_matrix_transpose
// Flat matrix store with element load/read and in-place transpose by pairwise
// swaps or cycle following over a visited map.
// ----------------------------------------------------------------------------
module in_place_matrix_transpose #(
	parameter int MAX_ELEMENTS  = 4096,
	parameter int ELEMENT_WIDTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ipmt_pkg::DIM_W-1:0] cfg_data,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  ipmt_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output ipmt_pkg::rsp_t             rsp
);

	import ipmt_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int EW = ELEMENT_WIDTH;

	state_t              state_q, state_d;
	logic [DIM_W-1:0]    cols_q, rows_q, cols_n, rows_n;
	logic [PROD_W-1:0]   total_q;
	logic [1:0]          op_q;
	logic                status_q, isread_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	logic [DIM_W-1:0]    i_q, j_q;
	logic [AW-1:0]       a_q, b_q, diag_q, diag_n, k_q, s_q, d_q;
	logic [EW-1:0]       c0_q;

	logic                accept, size_ok, idx_ok, out_free, s_last;
	logic [AW-1:0]       idx_addr;

	logic                st_we, st_re, vis_we, vis_re, vis_wdata;
	logic [AW-1:0]       st_waddr, st_raddr, vis_waddr, vis_raddr;
	logic [EW-1:0]       st_wdata, st_rdata;
	logic                vis_rdata;

	logic                div_start, div_busy;
	logic [AW-1:0]       div_dividend, div_quo;
	logic [DIM_W-1:0]    div_rem;

	assign accept   = req_valid && !req_stall;
	assign req_stall = state_q != ST_IDLE;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign size_ok  = total_q <= PROD_W'(MAX_ELEMENTS);
	assign idx_ok   = size_ok && (PROD_W'(req.index) < total_q)
	                  && (PROD_W'(req.index) < PROD_W'(MAX_ELEMENTS));
	assign idx_addr = AW'(req.index);
	assign diag_n   = diag_q + AW'(cols_q) + AW'(1);
	assign s_last   = (PROD_W'(s_q) + PROD_W'(2)) >= total_q;

	assign cols_n = (cfg_we && cfg_index == CFG_COLS) ? cfg_data : cols_q;
	assign rows_n = (cfg_we && cfg_index == CFG_ROWS) ? cfg_data : rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= DIM_W'(1);
			rows_q  <= DIM_W'(1);
			total_q <= PROD_W'(1);
		end else if (cfg_we) begin
			cols_q  <= cols_n;
			rows_q  <= rows_n;
			total_q <= PROD_W'(cols_n) * PROD_W'(rows_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RESP && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		st_we        = 1'b0;
		st_waddr     = a_q;
		st_wdata     = st_rdata;
		st_re        = 1'b0;
		st_raddr     = a_q;
		vis_we       = 1'b0;
		vis_waddr    = k_q;
		vis_wdata    = 1'b0;
		vis_re       = 1'b0;
		vis_raddr    = s_q;
		div_start    = 1'b0;
		div_dividend = s_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RESP;
					case (req.req_type)
						REQ_WRITE: begin
							st_we    = idx_ok;
							st_waddr = idx_addr;
							st_wdata = req.value[EW-1:0];
						end
						REQ_READ: begin
							st_re    = idx_ok;
							st_raddr = idx_addr;
						end
						REQ_TRANSPOSE: begin
							if (size_ok && cols_q >= DIM_W'(2) && rows_q >= DIM_W'(2)) begin
								state_d = (cols_q == rows_q) ? ST_SQ_RDA : ST_CLR;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SQ_RDA: begin
				st_re    = 1'b1;
				st_raddr = a_q;
				state_d  = ST_SQ_RDB;
			end
			ST_SQ_RDB: begin
				st_re    = 1'b1;
				st_raddr = b_q;
				state_d  = ST_SQ_WA;
			end
			ST_SQ_WA: begin
				st_we    = 1'b1;
				st_waddr = a_q;
				st_wdata = st_rdata;
				state_d  = ST_SQ_WB;
			end
			ST_SQ_WB: begin
				st_we    = 1'b1;
				st_waddr = b_q;
				st_wdata = c0_q;
				if (i_q == cols_q - DIM_W'(1) && j_q + DIM_W'(2) == cols_q) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_SQ_RDA;
				end
			end
			ST_CLR: begin
				vis_we    = 1'b1;
				vis_waddr = k_q;
				vis_wdata = 1'b0;
				if (k_q == AW'(total_q - PROD_W'(1))) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				vis_re    = 1'b1;
				vis_raddr = s_q;
				state_d   = ST_CHK2;
			end
			ST_CHK2: begin
				if (vis_rdata) begin
					state_d = s_last ? ST_RESP : ST_CHK;
				end else begin
					st_re        = 1'b1;
					st_raddr     = s_q;
					div_start    = 1'b1;
					div_dividend = s_q;
					state_d      = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				st_re    = 1'b1;
				st_raddr = d_q;
				state_d  = ST_WR;
			end
			ST_WR: begin
				st_we     = 1'b1;
				st_waddr  = d_q;
				st_wdata  = c0_q;
				vis_we    = 1'b1;
				vis_waddr = d_q;
				vis_wdata = 1'b1;
				if (d_q == s_q) begin
					state_d = s_last ? ST_RESP : ST_CHK;
				end else begin
					div_start    = 1'b1;
					div_dividend = d_q;
					state_d      = ST_DIV;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= req.req_type;
					isread_q <= (req.req_type == REQ_READ) && idx_ok;
					case (req.req_type)
						REQ_WRITE, REQ_READ: status_q <= idx_ok ? STAT_OK : STAT_ERR;
						REQ_TRANSPOSE:       status_q <= size_ok ? STAT_OK : STAT_ERR;
						default:             status_q <= STAT_ERR;
					endcase
					i_q    <= DIM_W'(1);
					j_q    <= '0;
					a_q    <= AW'(1);
					b_q    <= AW'(cols_q);
					diag_q <= '0;
					k_q    <= '0;
					s_q    <= AW'(1);
				end
			end
			ST_RESP: begin
				if (out_free) begin
					rsp_q.op_echo   <= op_q;
					rsp_q.status    <= status_q;
					rsp_q.read_data <= isread_q ? WORD_W'(st_rdata) : '0;
				end
			end
			ST_SQ_RDB: begin
				c0_q <= st_rdata;
			end
			ST_SQ_WB: begin
				if (i_q == cols_q - DIM_W'(1)) begin
					j_q    <= j_q + DIM_W'(1);
					i_q    <= j_q + DIM_W'(2);
					diag_q <= diag_n;
					a_q    <= diag_n + AW'(1);
					b_q    <= diag_n + AW'(cols_q);
				end else begin
					i_q <= i_q + DIM_W'(1);
					a_q <= a_q + AW'(1);
					b_q <= b_q + AW'(cols_q);
				end
			end
			ST_CLR: begin
				k_q <= k_q + AW'(1);
			end
			ST_CHK2: begin
				if (vis_rdata) begin
					s_q <= s_q + AW'(1);
				end
			end
			ST_LOAD: begin
				c0_q <= st_rdata;
			end
			ST_DIV: begin
				if (!div_busy) begin
					d_q <= AW'(PROD_W'(div_rem) * PROD_W'(rows_q) + PROD_W'(div_quo));
				end
			end
			ST_WR: begin
				c0_q <= st_rdata;
				if (d_q == s_q) begin
					s_q <= s_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	ipmt_ram #(.WIDTH(EW), .DEPTH(MAX_ELEMENTS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	ipmt_ram #(.WIDTH(1), .DEPTH(MAX_ELEMENTS)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (vis_re),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	ipmt_div #(.AW(AW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cols_q),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |-> PROD_W'(d_q) < total_q)
		else $error("cycle destination outside matrix");
	a_swap_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQ_WA |-> a_q != b_q)
		else $error("swap pair collapsed");
	a_resp_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP && out_free |=> rsp_valid_q && state_q == ST_IDLE)
		else $error("result not transferred to output register");
`endif

endmodule
